// ===== rtl/rgb565_run_length_encoder_assert.svh =====
// Assertion helpers for the RGB565 run-length encoder.
`ifndef RGB565_RUN_LENGTH_ENCODER_ASSERT_SVH
`define RGB565_RUN_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rle565 check failed");

// Next-cycle implication, disabled during reset.
`define RLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rle565 check failed");

`endif

// ===== rtl/rle565_pkg.sv =====
`default_nettype none

package rle565_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = 2;
    localparam int unsigned CNT_W       = 3;

    localparam logic [7:0] RUN_MAX      = 8'd255;
    localparam logic       ORDER_RGB    = 1'b0;

    typedef struct packed {
        logic [7:0]  len;
        logic [15:0] color;
        logic        done;
        logic        last;
    } t_run;

    function automatic logic [15:0] pack565(
        input logic       order,
        input logic [7:0] red,
        input logic [7:0] green,
        input logic [7:0] blue
    );
        logic [7:0] hi;
        logic [7:0] mid;
        hi  = (order == ORDER_RGB) ? red   : green;
        mid = (order == ORDER_RGB) ? green : red;
        return {hi[7:3], mid[7:2], blue[7:3]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb565_run_length_encoder.sv =====
// A taken pixel is registered first; its runs are pushed into the output queue once it can fire.
// Throughput: one pixel per cycle while runs drain at the pace they form;
// a pixel that closes a run and its frame pushes two runs into a 4-entry queue,
// so the pixel input stalls while fewer than two entries would be free after a pop.
// Reset (i_rst_n low, synchronous): queue empty, no open run, color order RGB.
`default_nettype none

module rgb565_run_length_encoder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire        i_cfg_wr_data,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [7:0] i_red_in,
    input  wire  [7:0] i_green_in,
    input  wire  [7:0] i_blue_in,
    input  wire        i_frame_last,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_run_length,
    output logic [7:0] o_color_high,
    output logic [7:0] o_color_low,
    output logic       o_frame_done,
    output logic       o_last_of_item
);

    logic                               r_color_order;
    logic                               r_in_valid;
    logic [7:0]                         r_in_red;
    logic [7:0]                         r_in_green;
    logic [7:0]                         r_in_blue;
    logic                               r_in_frame_last;
    logic [15:0]                        r_run_color;
    logic [7:0]                         r_run_count;
    rle565_pkg::t_run                   r_queue [rle565_pkg::QUEUE_DEPTH];
    logic [rle565_pkg::PTR_W-1:0]       r_wr_ptr;
    logic [rle565_pkg::PTR_W-1:0]       r_rd_ptr;
    logic [rle565_pkg::CNT_W-1:0]       r_cnt;

    logic [rle565_pkg::CNT_W-1:0]       n_cnt;
    logic [rle565_pkg::CNT_W-1:0]       cnt_after_pop;
    logic [rle565_pkg::CNT_W-1:0]       push_cnt;
    logic [rle565_pkg::PTR_W-1:0]       wr_ptr_next;
    logic                               in_take;
    logic                               pop;
    logic                               fire;
    logic [15:0]                        pix_color;
    logic                               run_close;
    logic [7:0]                         n_run_count;
    rle565_pkg::t_run                   close_run;
    rle565_pkg::t_run                   flush_run;
    rle565_pkg::t_run                   head;

    assign pop           = o_valid && !i_stall;
    assign cnt_after_pop = r_cnt - {{(rle565_pkg::CNT_W-1){1'b0}}, pop};
    assign fire          = r_in_valid &&
                           (cnt_after_pop <= rle565_pkg::CNT_W'(rle565_pkg::QUEUE_DEPTH - 2));
    assign o_stall       = r_in_valid && !fire;
    assign in_take       = i_valid && !o_stall;

    assign pix_color = rle565_pkg::pack565(r_color_order, r_in_red, r_in_green, r_in_blue);
    assign run_close = (r_run_count != 8'd0) &&
                       ((r_run_color != pix_color) || (r_run_count == rle565_pkg::RUN_MAX));
    assign n_run_count = run_close ? 8'd1 : (r_run_count + 8'd1);

    always_comb begin
        close_run.len   = r_run_count;
        close_run.color = r_run_color;
        close_run.done  = 1'b0;
        close_run.last  = !r_in_frame_last;
        flush_run.len   = n_run_count;
        flush_run.color = pix_color;
        flush_run.done  = 1'b1;
        flush_run.last  = 1'b1;
    end

    assign push_cnt = fire ? (rle565_pkg::CNT_W'(run_close) + rle565_pkg::CNT_W'(r_in_frame_last))
                           : '0;
    assign n_cnt       = cnt_after_pop + push_cnt;
    assign wr_ptr_next = r_wr_ptr + rle565_pkg::PTR_W'(1);

    assign head           = r_queue[r_rd_ptr];
    assign o_valid        = (r_cnt != '0);
    assign o_run_length   = head.len;
    assign o_color_high   = head.color[15:8];
    assign o_color_low    = head.color[7:0];
    assign o_frame_done   = head.done;
    assign o_last_of_item = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_order <= rle565_pkg::ORDER_RGB;
        end else if (i_cfg_wr_en) begin
            r_color_order <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_red        <= i_red_in;
            r_in_green      <= i_green_in;
            r_in_blue       <= i_blue_in;
            r_in_frame_last <= i_frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_color <= '0;
            r_run_count <= '0;
        end else if (fire) begin
            r_run_color <= pix_color;
            r_run_count <= r_in_frame_last ? 8'd0 : n_run_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && run_close) begin
            r_queue[r_wr_ptr] <= close_run;
        end else if (fire && r_in_frame_last) begin
            r_queue[r_wr_ptr] <= flush_run;
        end
        if (fire && run_close && r_in_frame_last) begin
            r_queue[wr_ptr_next] <= flush_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + rle565_pkg::PTR_W'(push_cnt);
            r_rd_ptr <= r_rd_ptr + rle565_pkg::PTR_W'(pop);
            r_cnt    <= n_cnt;
        end
    end

`include "rgb565_run_length_encoder_assert.svh"

    `RLE_ASSERT_IMP(a_queue_bound, i_clk, i_rst_n, 1'b1,
        r_cnt <= rle565_pkg::CNT_W'(rle565_pkg::QUEUE_DEPTH))
    `RLE_ASSERT_IMP(a_len_nonzero, i_clk, i_rst_n, o_valid, o_run_length != 8'd0)
    `RLE_ASSERT_IMP(a_done_is_last, i_clk, i_rst_n, o_valid && o_frame_done, o_last_of_item)
    `RLE_ASSERT_NEXT(a_frame_clears_run, i_clk, i_rst_n, fire && r_in_frame_last,
        r_run_count == 8'd0)

endmodule

`default_nettype wire
